// File: hw/rtl/eps_pkg.sv
// Shared types and constants for the encoder position servo.
// Used by eps_regs, eps_ctrl, eps_dp and encoder_position_pid_servo.
`default_nettype none

package eps_pkg;

  // Default width of the position counter
  localparam int POS_BITS_DEF = 32;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Datapath widths
  localparam int MUL_AW = 17;                 // unsigned gain/period plus a sign bit
  localparam int MUL_BW = 33;                 // error, error delta or integral
  localparam int PROD_W = MUL_AW + MUL_BW;    // signed product
  localparam int ISUM_W = PROD_W + 1;         // integral plus step
  localparam int ACC_W  = PROD_W + 1;         // kp*e + kd*d
  localparam int SUM_W  = ACC_W + 1;          // plus ki*I / 2^16
  localparam int FRAC_W = 16;                 // low part of ki*I kept aside
  localparam int S_W    = 19;                 // clamped sum, +-2^17
  localparam int V_W    = S_W + FRAC_W;       // control in Q24
  localparam int SUM_LIM = 131072;            // clamp of the Q8 sum

  localparam logic [7:0] DUTY_MAX = 8'hFF;

  // Reset values of the registers
  localparam logic [31:0] TARGET_RST = 32'd1137;
  localparam logic [15:0] KP_RST     = 16'd768;
  localparam logic [15:0] KI_RST     = 16'd128;
  localparam logic [15:0] KD_RST     = 16'd0;
  localparam logic [15:0] PERIOD_RST = 16'd131;
  localparam logic [30:0] ILIM_RST   = 31'd65536000;
  localparam logic [7:0]  MIN_DUTY_RST = 8'd50;
  localparam logic [7:0]  DEADBAND_RST = 8'd1;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_EDGE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_ZERO = 2'd2
  } kind_t;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_KP       = 3'd1,
    REG_KI       = 3'd2,
    REG_KD       = 3'd3,
    REG_PERIOD   = 3'd4,
    REG_ILIM     = 3'd5,
    REG_MIN_DUTY = 3'd6,
    REG_DEADBAND = 3'd7
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_MUL_IP = 3'd1,
    ST_INTEG  = 3'd2,
    ST_MUL_D  = 3'd3,
    ST_MUL_I  = 3'd4,
    ST_SUM    = 3'd5,
    ST_OUT    = 3'd6
  } state_t;

  // Multiplier operand select
  typedef enum logic [1:0] {
    MUL_E_PERIOD = 2'd0,
    MUL_KP_E     = 2'd1,
    MUL_KD_D     = 2'd2,
    MUL_KI_I     = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic [31:0] target;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [15:0] period;
    logic [30:0] ilim;
    logic [7:0]  min_duty;
    logic [7:0]  deadband;
  } cfg_t;

  typedef struct packed {
    logic     pos_inc;
    logic     pos_dec;
    logic     pos_clr;
    logic     tick_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     integ_upd;
    logic     acc_load;
    logic     acc_add;
    logic     sum_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/eps_regs.sv
// Configuration register file with an APB-style write/read port.
// Depends on eps_pkg for the register map, reset values and cfg_t.
`default_nettype none

module eps_regs
  import eps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_TARGET:   cfg_nxt.target   = pwdata[31:0];
        REG_KP:       cfg_nxt.kp       = pwdata[15:0];
        REG_KI:       cfg_nxt.ki       = pwdata[15:0];
        REG_KD:       cfg_nxt.kd       = pwdata[15:0];
        REG_PERIOD:   cfg_nxt.period   = pwdata[15:0];
        REG_ILIM:     cfg_nxt.ilim     = pwdata[30:0];
        REG_MIN_DUTY: cfg_nxt.min_duty = pwdata[7:0];
        REG_DEADBAND: cfg_nxt.deadband = pwdata[7:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target   <= TARGET_RST;
      cfg_r.kp       <= KP_RST;
      cfg_r.ki       <= KI_RST;
      cfg_r.kd       <= KD_RST;
      cfg_r.period   <= PERIOD_RST;
      cfg_r.ilim     <= ILIM_RST;
      cfg_r.min_duty <= MIN_DUTY_RST;
      cfg_r.deadband <= DEADBAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux, zero-extended
  always_comb begin
    case (idx)
      REG_TARGET:   prdata = cfg_r.target;
      REG_KP:       prdata = {16'b0, cfg_r.kp};
      REG_KI:       prdata = {16'b0, cfg_r.ki};
      REG_KD:       prdata = {16'b0, cfg_r.kd};
      REG_PERIOD:   prdata = {16'b0, cfg_r.period};
      REG_ILIM:     prdata = {1'b0, cfg_r.ilim};
      REG_MIN_DUTY: prdata = {24'b0, cfg_r.min_duty};
      REG_DEADBAND: prdata = {24'b0, cfg_r.deadband};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/eps_ctrl.sv
// Sequencer for the servo: accepts words and steps the datapath through a tick.
// Depends on eps_pkg for state_t, kind_t, dp_cmd_t and dp_stat_t.
`default_nettype none

module eps_ctrl
  import eps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  input  wire logic       in_b_level,
  output logic            in_stall,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_E_PERIOD;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_EDGE: begin
              cmd.pos_dec = in_b_level;
              cmd.pos_inc = !in_b_level;
            end
            KIND_ZERO: cmd.pos_clr = 1'b1;
            KIND_TICK: begin
              cmd.tick_load = 1'b1;
              state_nxt     = ST_MUL_IP;
            end
            default: ;
          endcase
        end
      end
      // e * period
      ST_MUL_IP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_E_PERIOD;
        state_nxt   = ST_INTEG;
      end
      // clamp the integral, start kp * e
      ST_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_KP_E;
        state_nxt     = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_KD_D;
        state_nxt    = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KI_I;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_load = 1'b1;
        state_nxt    = ST_OUT;
      end
      // wait for the result register to free up
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/eps_dp.sv
// Servo datapath: position counter, PID state, shared multiplier, result register.
// Depends on eps_pkg for widths, cfg_t, dp_cmd_t and dp_stat_t.
`default_nettype none

module eps_dp
  import eps_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire dp_cmd_t cmd,
  output dp_stat_t   stat,
  input  wire logic  out_stall,
  output logic       out_valid,
  output logic [7:0] out_duty,
  output logic       out_direction,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_error
);

  // Persistent state
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic signed [31:0]       integ_r, integ_nxt;
  logic signed [31:0]       last_err_r;

  // Per-tick working registers
  logic signed [31:0]        e_r, pos32_r;
  logic signed [MUL_BW-1:0]  d_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [S_W-1:0]     s_r, s_nxt;
  logic [FRAC_W-1:0]         blo_r;

  // Result register
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                duty_r, duty_nxt;
  logic                      dir_r, dir_nxt;
  logic signed [31:0]        opos_r, oerr_r;

  logic [63:0]               pos_ext;
  logic signed [31:0]        pos32, e_cur;
  logic signed [MUL_BW-1:0]  d_cur;
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic signed [ISUM_W-1:0]  isum, ilim;
  logic signed [SUM_W-1:0]   s_full, s_lim;
  logic signed [V_W-1:0]     v;
  logic [V_W-1:0]            mag;
  logic [7:0]                duty_raw;
  logic [31:0]               abse;

  // Position sampled as a 32-bit count
  assign pos_ext = {{(64 - POSITION_BITS){pos_r[POSITION_BITS-1]}}, pos_r};
  assign pos32   = pos_ext[31:0];
  assign e_cur   = cfg.target - pos32;
  assign d_cur   = {e_cur[31], e_cur} - {last_err_r[31], last_err_r};

  // Position counter
  always_comb begin
    pos_nxt = pos_r;
    if (cmd.pos_clr) begin
      pos_nxt = '0;
    end else if (cmd.pos_inc) begin
      pos_nxt = pos_r + POSITION_BITS'(1);
    end else if (cmd.pos_dec) begin
      pos_nxt = pos_r - POSITION_BITS'(1);
    end
  end

  // Shared multiplier, one product per step
  always_comb begin
    case (cmd.mul_sel)
      MUL_E_PERIOD: begin
        mul_a = $signed({1'b0, cfg.period});
        mul_b = $signed({e_r[31], e_r});
      end
      MUL_KP_E: begin
        mul_a = $signed({1'b0, cfg.kp});
        mul_b = $signed({e_r[31], e_r});
      end
      MUL_KD_D: begin
        mul_a = $signed({1'b0, cfg.kd});
        mul_b = d_r;
      end
      MUL_KI_I: begin
        mul_a = $signed({1'b0, cfg.ki});
        mul_b = $signed({integ_r[31], integ_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Integral step with symmetric clamp
  always_comb begin
    isum = ISUM_W'(integ_r) + ISUM_W'(prod_r);
    ilim = $signed(ISUM_W'({1'b0, cfg.ilim}));
    if (isum > ilim) begin
      integ_nxt = 32'(ilim);
    end else if (isum < -ilim) begin
      integ_nxt = 32'(-ilim);
    end else begin
      integ_nxt = 32'(isum);
    end
  end

  // kp*e + kd*d accumulation
  assign acc_nxt = cmd.acc_load ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  // Add the whole part of ki*I and clamp
  always_comb begin
    s_full = SUM_W'(acc_r) + SUM_W'(prod_r >>> FRAC_W);
    s_lim  = SUM_W'(SUM_LIM);
    if (s_full > s_lim) begin
      s_nxt = S_W'(s_lim);
    end else if (s_full < -s_lim) begin
      s_nxt = S_W'(-s_lim);
    end else begin
      s_nxt = S_W'(s_full);
    end
  end

  // Direction, duty and minimum duty outside the deadband
  always_comb begin
    v        = $signed({s_r, blo_r});
    dir_nxt  = !v[V_W-1] && (v != '0);
    mag      = v[V_W-1] ? V_W'(-v) : V_W'(v);
    duty_raw = (|mag[V_W-1:32]) ? DUTY_MAX : mag[31:24];
    abse     = e_r[31] ? 32'(-e_r) : 32'(e_r);
    duty_nxt = duty_raw;
    if ((abse > {24'b0, cfg.deadband}) && (duty_raw < cfg.min_duty)) begin
      duty_nxt = cfg.min_duty;
    end
  end

  // Result handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || !out_stall;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      integ_r     <= '0;
      last_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.tick_load) begin
        last_err_r <= e_cur;
      end
      if (cmd.integ_upd) begin
        integ_r <= integ_nxt;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.tick_load) begin
      e_r     <= e_cur;
      d_r     <= d_cur;
      pos32_r <= pos32;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_load || cmd.acc_add) begin
      acc_r <= acc_nxt;
    end
    if (cmd.sum_load) begin
      s_r   <= s_nxt;
      blo_r <= prod_r[FRAC_W-1:0];
    end
    if (cmd.out_load) begin
      duty_r <= duty_nxt;
      dir_r  <= dir_nxt;
      opos_r <= pos32_r;
      oerr_r <= e_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_duty      = duty_r;
  assign out_direction = dir_r;
  assign out_position  = opos_r;
  assign out_error     = oerr_r;

endmodule

`default_nettype wire

// File: hw/rtl/encoder_position_pid_servo.sv
// Top level of the encoder position servo: register file, sequencer, datapath.
// Depends on eps_pkg, eps_regs, eps_ctrl and eps_dp.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_kind, in_b_level
//   out_      output     out_valid/out_stall out_duty, out_direction, out_position, out_error
//   cfg       APB slave  psel/penable/pready paddr, pwdata, prdata (word i at 4*i)
//
// An edge or zero word is taken while the sequencer is idle. A tick stalls the input until
// its result is loaded: one shared 17x33 multiplier forms e*period, kp*e, kd*e_delta and
// ki*I in turn, with the integral clamp between them and the final sum after.
// Reset (rst_n low, synchronous) clears position, integral, last error and the
// result valid, and loads the register defaults. A stalled result holds; the next
// word is taken meanwhile, and a later tick waits in its last step for the slot.
`default_nettype none

module encoder_position_pid_servo
  import eps_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_kind,
  input  wire logic              in_b_level,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_duty,
  output logic                   out_direction,
  output logic signed [31:0]     out_position,
  output logic signed [31:0]     out_error,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  eps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_kind    (in_kind),
    .in_b_level (in_b_level),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  eps_dp #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_duty      (out_duty),
    .out_direction (out_direction),
    .out_position  (out_position),
    .out_error     (out_error)
  );

endmodule

`default_nettype wire
